[rtl/core/m4te_pkg.sv]
`timescale 1ns / 1ps

package m4te_pkg;

    typedef logic signed [31:0] elem_t;
    typedef logic signed [63:0] wide_t;
    typedef logic [1:0]         op_t;
    typedef logic [1:0]         col_t;

    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_MUL   = 2'd1;
    localparam op_t OP_TRANS = 2'd2;
    localparam op_t OP_SCALE = 2'd3;

    localparam col_t COL_LAST = 2'd3;

    localparam wide_t ELEM_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam wide_t ELEM_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        elem_t value;
        logic  sat;
    } clamp_t;

    // per-lane findings handed to the merge logic
    typedef struct packed {
        elem_t       sum;
        logic        sum_sat;
        elem_t [2:0] scl;
        logic  [2:0] scl_sat;
    } lane_res_t;

    function automatic clamp_t clamp32(input wide_t v);
        clamp_t r;
        if (v > ELEM_MAX) begin
            r.value = ELEM_MAX[31:0];
            r.sat   = 1'b1;
        end else if (v < ELEM_MIN) begin
            r.value = ELEM_MIN[31:0];
            r.sat   = 1'b1;
        end else begin
            r.value = v[31:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/m4te_lane.sv]
`timescale 1ns / 1ps

// One matrix row: four registered products, then floor shift, sum and clamp.
module m4te_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                capture,
    input  logic                use_offset,
    input  m4te_pkg::elem_t     mat_row [4],
    input  m4te_pkg::elem_t     elem    [4],
    output m4te_pkg::lane_res_t res
);

    m4te_pkg::wide_t prod_reg  [4];
    m4te_pkg::wide_t prod_next [4];
    m4te_pkg::elem_t offs_reg;
    m4te_pkg::wide_t shifted   [4];
    m4te_pkg::wide_t offs_ext;
    m4te_pkg::wide_t acc;
    m4te_pkg::clamp_t sum_c;
    m4te_pkg::clamp_t scl_c [3];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            prod_next[c] = mat_row[c] * elem[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            prod_reg <= prod_next;
            offs_reg <= mat_row[3];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            shifted[c] = prod_reg[c] >>> FRAC_BITS;   // floor
        end
        offs_ext = $signed({{32{offs_reg[31]}}, offs_reg});
        acc = shifted[0] + shifted[1] + shifted[2] + (use_offset ? offs_ext : shifted[3]);
        sum_c = m4te_pkg::clamp32(acc);
        for (int c = 0; c < 3; c++) begin
            scl_c[c] = m4te_pkg::clamp32(shifted[c]);
        end
        res.sum     = sum_c.value;
        res.sum_sat = sum_c.sat;
        for (int c = 0; c < 3; c++) begin
            res.scl[c]     = scl_c[c].value;
            res.scl_sat[c] = scl_c[c].sat;
        end
    end

endmodule

[rtl/core/mat4_transform_engine.sv]
`timescale 1ns / 1ps
// An accepted item passes the product stage, then the output register, before m_valid.
// Throughput: 1 item per cycle for loads and column 0-2 multiplies, unless the output
// stalls; an item that rewrites the matrix (column 3 multiply, translate, scale) keeps
// s_ready low in the product stage, since multipliers read the matrix at accept.
// Reset (aresetn low, synchronous): matrix returns to identity, pipeline emptied.
module mat4_transform_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [1:0]          s_col_index,
    input  logic signed [31:0]  s_elem_0,
    input  logic signed [31:0]  s_elem_1,
    input  logic signed [31:0]  s_elem_2,
    input  logic signed [31:0]  s_elem_3,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_out_column,
    output logic signed [31:0]  m_out_row_0,
    output logic signed [31:0]  m_out_row_1,
    output logic signed [31:0]  m_out_row_2,
    output logic signed [31:0]  m_out_row_3,
    output logic                m_saturated
);

    localparam m4te_pkg::elem_t ONE = 32'(64'd1 << FRAC_BITS);

    // matrix, column-major: mat_reg[col][row]
    m4te_pkg::elem_t mat_reg  [4][4];
    // pending product columns; never read before written by legal use
    m4te_pkg::elem_t pend_reg [4][4];

    // product stage
    logic            a_valid_reg;
    m4te_pkg::op_t   a_op_reg;
    m4te_pkg::col_t  a_col_reg;
    m4te_pkg::elem_t a_elem_reg [4];

    // output register
    logic            m_valid_reg;
    m4te_pkg::col_t  m_col_reg;
    m4te_pkg::elem_t m_row_reg  [4];
    logic            m_sat_reg;

    m4te_pkg::elem_t   s_elem  [4];
    m4te_pkg::elem_t   lane_row [4][4];   // [row][col]
    m4te_pkg::lane_res_t lane_res [4];

    logic accept;
    logic out_free;
    logic a_adv;
    logic a_writes_m;
    logic use_offset;

    m4te_pkg::col_t  m_col_next;
    m4te_pkg::elem_t m_row_next [4];
    logic            m_sat_next;

    assign s_elem[0] = s_elem_0;
    assign s_elem[1] = s_elem_1;
    assign s_elem[2] = s_elem_2;
    assign s_elem[3] = s_elem_3;

    // ---------------- handshake / hazard control ----------------
    assign out_free   = !m_valid_reg || m_ready;
    assign a_adv      = a_valid_reg && out_free;
    // items in the product stage that update the matrix when they retire
    assign a_writes_m = (a_op_reg == m4te_pkg::OP_MUL && a_col_reg == m4te_pkg::COL_LAST)
                     || (a_op_reg == m4te_pkg::OP_TRANS)
                     || (a_op_reg == m4te_pkg::OP_SCALE);
    // the multipliers read the matrix at accept, so wait for a pending matrix update
    assign s_ready    = (!a_valid_reg || a_adv) && !(a_valid_reg && a_writes_m);
    assign accept     = s_valid && s_ready;
    assign use_offset = (a_op_reg == m4te_pkg::OP_TRANS);

    // ---------------- lanes: one per matrix row ----------------
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                lane_row[r][c] = mat_reg[c][r];
            end
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_lane
        m4te_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk       (aclk),
            .capture    (accept),
            .use_offset (use_offset),
            .mat_row    (lane_row[r]),
            .elem       (s_elem),
            .res        (lane_res[r])
        );
    end

    // ---------------- merge: pick the returned column ----------------
    always_comb begin
        m_col_next = a_col_reg;
        m_sat_next = 1'b0;
        for (int r = 0; r < 4; r++) begin
            m_row_next[r] = a_elem_reg[r];
        end
        case (a_op_reg)
            m4te_pkg::OP_LOAD: begin
                m_col_next = a_col_reg;
            end
            m4te_pkg::OP_MUL, m4te_pkg::OP_TRANS: begin
                if (a_op_reg == m4te_pkg::OP_TRANS) begin
                    m_col_next = m4te_pkg::COL_LAST;
                end
                for (int r = 0; r < 4; r++) begin
                    m_row_next[r] = lane_res[r].sum;
                    m_sat_next    = m_sat_next | lane_res[r].sum_sat;
                end
            end
            m4te_pkg::OP_SCALE: begin
                // only clamps in the returned column count; column 3 is untouched
                for (int r = 0; r < 4; r++) begin
                    case (a_col_reg)
                        2'd0: begin
                            m_row_next[r] = lane_res[r].scl[0];
                            m_sat_next    = m_sat_next | lane_res[r].scl_sat[0];
                        end
                        2'd1: begin
                            m_row_next[r] = lane_res[r].scl[1];
                            m_sat_next    = m_sat_next | lane_res[r].scl_sat[1];
                        end
                        2'd2: begin
                            m_row_next[r] = lane_res[r].scl[2];
                            m_sat_next    = m_sat_next | lane_res[r].scl_sat[2];
                        end
                        default: begin
                            m_row_next[r] = mat_reg[3][r];
                        end
                    endcase
                end
            end
            default: begin
                m_col_next = a_col_reg;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_op_reg   <= s_opcode;
            a_col_reg  <= s_col_index;
            a_elem_reg <= s_elem;
        end
        if (a_adv) begin
            m_col_reg <= m_col_next;
            m_row_reg <= m_row_next;
            m_sat_reg <= m_sat_next;
        end
        if (a_adv && a_op_reg == m4te_pkg::OP_MUL) begin
            for (int r = 0; r < 4; r++) begin
                pend_reg[a_col_reg][r] <= lane_res[r].sum;
            end
        end
    end

    // ---------------- matrix ----------------
    // A load writes at accept; other updates land when the item retires. Both never
    // coincide, since s_ready is low while a matrix-updating item is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    mat_reg[c][r] <= (c == r) ? ONE : '0;
                end
            end
        end else begin
            if (accept && s_opcode == m4te_pkg::OP_LOAD) begin
                mat_reg[s_col_index] <= s_elem;
            end
            if (a_adv) begin
                case (a_op_reg)
                    m4te_pkg::OP_MUL: begin
                        if (a_col_reg == m4te_pkg::COL_LAST) begin
                            // commit: pending columns 0-2 plus the fresh column 3
                            for (int c = 0; c < 3; c++) begin
                                mat_reg[c] <= pend_reg[c];
                            end
                            for (int r = 0; r < 4; r++) begin
                                mat_reg[3][r] <= lane_res[r].sum;
                            end
                        end
                    end
                    m4te_pkg::OP_TRANS: begin
                        for (int r = 0; r < 4; r++) begin
                            mat_reg[3][r] <= lane_res[r].sum;
                        end
                    end
                    m4te_pkg::OP_SCALE: begin
                        for (int c = 0; c < 3; c++) begin
                            for (int r = 0; r < 4; r++) begin
                                mat_reg[c][r] <= lane_res[r].scl[c];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_column = m_col_reg;
    assign m_out_row_0  = m_row_reg[0];
    assign m_out_row_1  = m_row_reg[1];
    assign m_out_row_2  = m_row_reg[2];
    assign m_out_row_3  = m_row_reg[3];
    assign m_saturated  = m_sat_reg;

    // ---------------- assertions ----------------
    // no new item while a matrix update is still in flight
    a_hazard_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && a_writes_m |-> !s_ready)
        else $error("item accepted over a pending matrix update");

    // the product stage is never overwritten while its item waits for the output
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !out_free |=> a_valid_reg && $stable(a_op_reg) && $stable(a_col_reg))
        else $error("product stage overwritten");

    // translate always returns column 3
    a_trans_col: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv && a_op_reg == m4te_pkg::OP_TRANS |=> m_valid && m_out_column == m4te_pkg::COL_LAST)
        else $error("translate returned wrong column");

endmodule
